/* hdl/stt_pkg.sv */
// stt_pkg: shared types, token and error codes, scan modes and character
// constants for the source text tokenizer
// no dependencies
`default_nettype none
package stt_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    typedef enum logic [4:0] {
        KIND_LPAREN        = 5'd0,
        KIND_RPAREN        = 5'd1,
        KIND_LBRACE        = 5'd2,
        KIND_RBRACE        = 5'd3,
        KIND_COMMA         = 5'd4,
        KIND_DOT           = 5'd5,
        KIND_MINUS         = 5'd6,
        KIND_PLUS          = 5'd7,
        KIND_SEMICOLON     = 5'd8,
        KIND_SLASH         = 5'd9,
        KIND_STAR          = 5'd10,
        KIND_BANG          = 5'd11,
        KIND_BANG_EQUAL    = 5'd12,
        KIND_EQUAL         = 5'd13,
        KIND_EQUAL_EQUAL   = 5'd14,
        KIND_GREATER       = 5'd15,
        KIND_GREATER_EQUAL = 5'd16,
        KIND_LESS          = 5'd17,
        KIND_LESS_EQUAL    = 5'd18,
        KIND_IDENT         = 5'd19,
        KIND_STRING        = 5'd20,
        KIND_NUMBER        = 5'd21,
        KIND_ERROR         = 5'd22,
        KIND_END           = 5'd23
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNEXPECTED   = 2'd1,
        ERR_UNTERMINATED = 2'd2
    } error_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_NUMDOT  = 3'd3,
        MODE_FRAC    = 3'd4,
        MODE_STRING  = 3'd5,
        MODE_COMMENT = 3'd6,
        MODE_OPER    = 3'd7
    } scan_mode_t;

    typedef enum logic [1:0] {
        OPER_BANG    = 2'd0,
        OPER_EQUAL   = 2'd1,
        OPER_LESS    = 2'd2,
        OPER_GREATER = 2'd3
    } oper_t;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACE    = 8'h7b;
    localparam logic [7:0] CH_RBRACE    = 8'h7d;
    localparam logic [7:0] CH_COMMA     = 8'h2c;
    localparam logic [7:0] CH_DOT       = 8'h2e;
    localparam logic [7:0] CH_MINUS     = 8'h2d;
    localparam logic [7:0] CH_PLUS      = 8'h2b;
    localparam logic [7:0] CH_SEMICOLON = 8'h3b;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_STAR      = 8'h2a;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_EQUAL     = 8'h3d;
    localparam logic [7:0] CH_LESS      = 8'h3c;
    localparam logic [7:0] CH_GREATER   = 8'h3e;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
    localparam logic [7:0] CH_UPPER_LO  = 8'h41;
    localparam logic [7:0] CH_UPPER_HI  = 8'h5a;
    localparam logic [7:0] CH_LOWER_LO  = 8'h61;
    localparam logic [7:0] CH_LOWER_HI  = 8'h7a;

    typedef struct packed {
        token_kind_t              kind;
        logic [OFFSET_BITS-1:0]   start;
        logic [OFFSET_BITS-1:0]   length;
        error_kind_t              err;
    } token_t;

    // tokens completed by one input beat, packed from slot 0
    typedef struct packed {
        logic [1:0]             count;
        logic [LINE_BITS-1:0]   line;
        token_t [2:0]           tok;
    } group_t;

endpackage
`default_nettype wire

/* hdl/stt_front.sv */
// stt_front: scanner state machine, classifies each source byte and builds
// the group of tokens that the byte completes
// depends on stt_pkg
`default_nettype none
module stt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      char_byte,
    input  wire logic            end_of_source,
    output logic                 push,
    output stt_pkg::group_t      group
);
    import stt_pkg::*;

    scan_mode_t               mode_reg, mode_next;
    oper_t                    pend_reg, pend_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [OFFSET_BITS-1:0]   cur_reg, cur_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;

    scan_mode_t   idle_mode;
    oper_t        idle_pend;
    logic         idle_emit;
    token_kind_t  idle_kind;
    error_kind_t  idle_err;
    logic         idle_nl;

    logic                     a_v, b_v, c_v, nl, use_idle;
    token_t                   tok_a, tok_b, tok_c;
    logic [OFFSET_BITS-1:0]   len, dpos;
    logic                     is_dig, is_alp;

    function automatic token_kind_t oper_kind(input oper_t op, input logic with_eq);
        token_kind_t k;
        begin
            case (op)
                OPER_BANG:    k = with_eq ? KIND_BANG_EQUAL : KIND_BANG;
                OPER_EQUAL:   k = with_eq ? KIND_EQUAL_EQUAL : KIND_EQUAL;
                OPER_LESS:    k = with_eq ? KIND_LESS_EQUAL : KIND_LESS;
                OPER_GREATER: k = with_eq ? KIND_GREATER_EQUAL : KIND_GREATER;
                default:      k = KIND_BANG;
            endcase
            return k;
        end
    endfunction

    assign is_dig = (char_byte >= CH_DIGIT_LO) && (char_byte <= CH_DIGIT_HI);
    assign is_alp = ((char_byte >= CH_LOWER_LO) && (char_byte <= CH_LOWER_HI))
                 || ((char_byte >= CH_UPPER_LO) && (char_byte <= CH_UPPER_HI))
                 || (char_byte == CH_UNDERSCORE);
    assign len  = cur_reg - start_reg;
    assign dpos = (cur_reg > start_reg) ? (cur_reg - 1'b1) : start_reg;

    // classification of a byte seen between tokens
    always_comb
    begin
        idle_mode = MODE_IDLE;
        idle_pend = OPER_BANG;
        idle_emit = 1'b0;
        idle_kind = KIND_ERROR;
        idle_err  = ERR_NONE;
        idle_nl   = 1'b0;
        if (is_dig)
        begin
            idle_mode = MODE_NUMBER;
        end
        else if (is_alp)
        begin
            idle_mode = MODE_IDENT;
        end
        else
        begin
            case (char_byte)
                CH_SPACE, CH_CR, CH_TAB: idle_mode = MODE_IDLE;
                CH_NEWLINE:   idle_nl = 1'b1;
                CH_HASH:      idle_mode = MODE_COMMENT;
                CH_QUOTE:     idle_mode = MODE_STRING;
                CH_LPAREN:    begin idle_emit = 1'b1; idle_kind = KIND_LPAREN;    end
                CH_RPAREN:    begin idle_emit = 1'b1; idle_kind = KIND_RPAREN;    end
                CH_LBRACE:    begin idle_emit = 1'b1; idle_kind = KIND_LBRACE;    end
                CH_RBRACE:    begin idle_emit = 1'b1; idle_kind = KIND_RBRACE;    end
                CH_COMMA:     begin idle_emit = 1'b1; idle_kind = KIND_COMMA;     end
                CH_DOT:       begin idle_emit = 1'b1; idle_kind = KIND_DOT;       end
                CH_MINUS:     begin idle_emit = 1'b1; idle_kind = KIND_MINUS;     end
                CH_PLUS:      begin idle_emit = 1'b1; idle_kind = KIND_PLUS;      end
                CH_SEMICOLON: begin idle_emit = 1'b1; idle_kind = KIND_SEMICOLON; end
                CH_SLASH:     begin idle_emit = 1'b1; idle_kind = KIND_SLASH;     end
                CH_STAR:      begin idle_emit = 1'b1; idle_kind = KIND_STAR;      end
                CH_BANG:      begin idle_mode = MODE_OPER; idle_pend = OPER_BANG;    end
                CH_EQUAL:     begin idle_mode = MODE_OPER; idle_pend = OPER_EQUAL;   end
                CH_LESS:      begin idle_mode = MODE_OPER; idle_pend = OPER_LESS;    end
                CH_GREATER:   begin idle_mode = MODE_OPER; idle_pend = OPER_GREATER; end
                default:
                begin
                    idle_emit = 1'b1;
                    idle_kind = KIND_ERROR;
                    idle_err  = ERR_UNEXPECTED;
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        c_v        = 1'b0;
        nl         = 1'b0;
        use_idle   = 1'b0;
        tok_a      = '{kind: KIND_NUMBER, start: start_reg, length: len, err: ERR_NONE};
        tok_b      = '{kind: KIND_DOT, start: dpos, length: OFFSET_BITS'(1), err: ERR_NONE};
        tok_c      = '{kind: idle_kind, start: cur_reg, length: OFFSET_BITS'(1),
                       err: idle_err};
        if (end_of_source)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    a_v = 1'b1;
                    tok_a.kind = KIND_IDENT;
                end
                MODE_NUMBER, MODE_FRAC: a_v = 1'b1;
                MODE_NUMDOT:
                begin
                    a_v = 1'b1;
                    b_v = 1'b1;
                    tok_a.length = dpos - start_reg;
                end
                MODE_STRING:
                begin
                    a_v = 1'b1;
                    tok_a.kind = KIND_ERROR;
                    tok_a.err  = ERR_UNTERMINATED;
                end
                MODE_OPER:
                begin
                    a_v = 1'b1;
                    tok_a.kind = oper_kind(pend_reg, 1'b0);
                end
                default: a_v = 1'b0;
            endcase
            c_v        = 1'b1;
            tok_c      = '{kind: KIND_END, start: cur_reg, length: '0, err: ERR_NONE};
            start_next = cur_reg;
            mode_next  = MODE_IDLE;
            pend_next  = OPER_BANG;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (!(is_alp || is_dig))
                    begin
                        a_v        = 1'b1;
                        tok_a.kind = KIND_IDENT;
                        use_idle   = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (char_byte == CH_DOT)
                    begin
                        mode_next = MODE_NUMDOT;
                    end
                    else if (!is_dig)
                    begin
                        a_v      = 1'b1;
                        use_idle = 1'b1;
                    end
                end
                MODE_NUMDOT:
                begin
                    if (is_dig)
                    begin
                        mode_next = MODE_FRAC;
                    end
                    else
                    begin
                        a_v          = 1'b1;
                        b_v          = 1'b1;
                        tok_a.length = dpos - start_reg;
                        use_idle     = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (!is_dig)
                    begin
                        a_v      = 1'b1;
                        use_idle = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    nl = (char_byte == CH_NEWLINE);
                    if (char_byte == CH_QUOTE)
                    begin
                        a_v          = 1'b1;
                        tok_a.kind   = KIND_STRING;
                        tok_a.length = len + 1'b1;
                        mode_next    = MODE_IDLE;
                    end
                end
                MODE_COMMENT:
                begin
                    if (char_byte == CH_NEWLINE)
                    begin
                        nl        = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_OPER:
                begin
                    a_v       = 1'b1;
                    pend_next = OPER_BANG;
                    if (char_byte == CH_EQUAL)
                    begin
                        tok_a.kind   = oper_kind(pend_reg, 1'b1);
                        tok_a.length = len + 1'b1;
                        mode_next    = MODE_IDLE;
                    end
                    else
                    begin
                        tok_a.kind = oper_kind(pend_reg, 1'b0);
                        use_idle   = 1'b1;
                    end
                end
                default: use_idle = 1'b1;
            endcase
            if (use_idle)
            begin
                mode_next  = idle_mode;
                start_next = cur_reg;
                c_v        = idle_emit;
                nl         = idle_nl;
                if (idle_mode == MODE_OPER)
                begin
                    pend_next = idle_pend;
                end
            end
            if (cur_reg != '1)
            begin
                cur_next = cur_reg + 1'b1;
            end
        end
        line_next = (nl && (line_reg != '1)) ? (line_reg + 1'b1) : line_reg;
    end

    // pack tokens from slot 0
    always_comb
    begin
        group.line  = line_reg;
        group.count = 2'(a_v) + 2'(b_v) + 2'(c_v);
        group.tok   = {tok_c, tok_b, tok_a};
        if (!a_v)
        begin
            group.tok[0] = tok_c;
        end
        else if (!b_v)
        begin
            group.tok[1] = tok_c;
        end
    end

    assign push = take && (a_v || c_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= OPER_BANG;
            start_reg <= '0;
            cur_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            start_reg <= start_next;
            cur_reg   <= cur_next;
            line_reg  <= line_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/stt_queue.sv */
// stt_queue: short queue of token groups between scanner and emitter
// depends on stt_pkg
`default_nettype none
module stt_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire stt_pkg::group_t push_group,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output stt_pkg::group_t      head
);
    import stt_pkg::*;

    group_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     fill_reg, fill_next;
    logic                   do_push, do_pop;

    assign full       = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/stt_back.sv */
// stt_back: emitter, walks the tokens of the head group and presents them
// one per beat from an output register
// depends on stt_pkg
`default_nettype none
module stt_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               head_valid,
    input  wire stt_pkg::group_t                    head,
    output logic                                    pop,
    output logic                                    tok_valid,
    input  wire logic                               tok_ready,
    output logic [4:0]                              token_kind,
    output logic [stt_pkg::OFFSET_BITS-1:0]         start_offset,
    output logic [stt_pkg::OFFSET_BITS-1:0]         token_length,
    output logic [stt_pkg::LINE_BITS-1:0]           line_number,
    output logic [1:0]                              error_kind,
    output logic                                    last_of_run
);
    import stt_pkg::*;

    logic [1:0]             idx_reg, idx_next;
    logic                   tok_valid_reg, tok_valid_next;
    token_t                 tok_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic                   last_reg;
    logic                   load, at_last;

    assign load    = head_valid && (!tok_valid_reg || tok_ready);
    assign at_last = (idx_reg == (head.count - 2'd1));
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        tok_valid_next = tok_valid_reg;
        if (load)
        begin
            idx_next       = at_last ? 2'd0 : (idx_reg + 2'd1);
            tok_valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            tok_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= head.tok[idx_reg];
            line_reg <= head.line;
            last_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    assign tok_valid    = tok_valid_reg;
    assign token_kind   = tok_reg.kind;
    assign start_offset = tok_reg.start;
    assign token_length = tok_reg.length;
    assign line_number  = line_reg;
    assign error_kind   = tok_reg.err;
    assign last_of_run  = last_reg;

endmodule
`default_nettype wire

/* hdl/source_text_tokenizer.sv */
// source_text_tokenizer: top level, scanner front, group queue, token emitter
// depends on stt_pkg, stt_front, stt_queue, stt_back
//
//   channel | valid / ready       | beat payload
//   --------+---------------------+---------------------------------------------
//   source  | src_valid/src_ready | char_byte, end_of_source
//   tokens  | tok_valid/tok_ready | token_kind, start_offset, token_length,
//           |                     | line_number, error_kind, last_of_run
//
// one source beat per cycle while the four-group queue has room
// a beat's tokens (up to three) pass the queue memory, then the emitter output register
// the emitter output register sets the rate: one token per cycle while tok_ready is high
// src_ready drops only when the queue is full; tok_ready stalls back up into the queue
// reset clears scan state to idle, offset 0, line 1, and empties the queue
`default_nettype none
module source_text_tokenizer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               src_valid,
    output logic                                    src_ready,
    input  wire logic [7:0]                         char_byte,
    input  wire logic                               end_of_source,
    output logic                                    tok_valid,
    input  wire logic                               tok_ready,
    output logic [4:0]                              token_kind,
    output logic [stt_pkg::OFFSET_BITS-1:0]         start_offset,
    output logic [stt_pkg::OFFSET_BITS-1:0]         token_length,
    output logic [stt_pkg::LINE_BITS-1:0]           line_number,
    output logic [1:0]                              error_kind,
    output logic                                    last_of_run
);
    import stt_pkg::*;

    logic     take, push, full, pop, head_valid;
    group_t   push_group, head;

    assign src_ready = !full;
    assign take      = src_valid && src_ready;

    stt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .char_byte     (char_byte),
        .end_of_source (end_of_source),
        .push          (push),
        .group         (push_group)
    );

    stt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    stt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .tok_valid    (tok_valid),
        .tok_ready    (tok_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .error_kind   (error_kind),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire

/* hdl/stt_checker.sv */
// stt_checker: port-level checks on the token channel, bound to the top level
// depends on stt_pkg and source_text_tokenizer
`default_nettype none
module stt_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               tok_valid,
    input  wire logic                               tok_ready,
    input  wire logic [4:0]                         token_kind,
    input  wire logic [stt_pkg::OFFSET_BITS-1:0]    token_length,
    input  wire logic [stt_pkg::LINE_BITS-1:0]      line_number,
    input  wire logic [1:0]                         error_kind,
    input  wire logic                               last_of_run
);
    import stt_pkg::*;

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(token_kind)
                                    && $stable(token_length))
        else $error("token beat dropped or changed while stalled");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> ((token_kind == KIND_ERROR) == (error_kind != ERR_NONE)))
        else $error("error code does not match token kind");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind == KIND_END |-> token_length == '0 && last_of_run)
        else $error("end token not empty or not last of run");

    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> line_number != '0)
        else $error("line number zero");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tok_valid    (tok_valid),
    .tok_ready    (tok_ready),
    .token_kind   (token_kind),
    .token_length (token_length),
    .line_number  (line_number),
    .error_kind   (error_kind),
    .last_of_run  (last_of_run)
);
`default_nettype wire
